// File: src/twdc_pkg.sv
package twdc_pkg;

   // field widths
   localparam int MODE_W      = 3;
   localparam int VALUE_W     = 16;
   localparam int DUTY_W      = 14;
   localparam int LEVEL_W     = 8;
   localparam int TEMP_W      = 16;
   localparam int BOOT_CNT_W  = 8;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int SPM_W       = 2;

   // parameter defaults
   localparam int unsigned DUTY_FULL_SCALE_DEFAULT = 8192;
   localparam int unsigned REBOOT_LIMIT_DEFAULT    = 5;

   // event codes
   localparam logic [MODE_W-1:0] MODE_SET_POWER    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SET_LEVEL    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SET_TEMP     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BOOT_RESTORE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BOOT_CONFIRM = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_STARTUP_POWER_MODE  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STARTUP_TEMPERATURE = 8'd1;

   // startup power modes
   localparam logic [SPM_W-1:0] SPM_OFF    = 2'd0;
   localparam logic [SPM_W-1:0] SPM_ON     = 2'd1;
   localparam logic [SPM_W-1:0] SPM_TOGGLE = 2'd2;
   localparam logic [SPM_W-1:0] SPM_KEEP   = 2'd3;

   // special values
   localparam logic [TEMP_W-1:0]     KEEP_TEMPERATURE = 16'hFFFF;
   localparam logic [LEVEL_W-1:0]    LEVEL_OFF        = 8'h00;
   localparam logic [LEVEL_W-1:0]    LEVEL_ON         = 8'hFF;
   localparam logic [BOOT_CNT_W-1:0] BOOT_CNT_MAX     = 8'hFF;

   // reset values
   localparam logic [SPM_W-1:0]   RST_STARTUP_POWER_MODE = SPM_ON;
   localparam logic [TEMP_W-1:0]  RST_STARTUP_TEMP       = KEEP_TEMPERATURE;
   localparam logic [LEVEL_W-1:0] RST_LEVEL              = 8'd254;
   localparam logic [TEMP_W-1:0]  RST_TEMP               = 16'd250;

   // ramp breakpoints in mireds
   localparam logic [TEMP_W-1:0] T_WARM_FULL  = 16'd370;
   localparam logic [TEMP_W-1:0] T_COLD_STEEP = 16'd454;
   localparam logic [TEMP_W-1:0] T_COLD_END   = 16'd500;
   localparam logic [TEMP_W-1:0] T_COLD_BASE  = 16'd538;
   localparam logic [TEMP_W-1:0] T_WARM_STEEP = 16'd250;
   localparam logic [TEMP_W-1:0] T_WARM_BASE  = 16'd130;
   localparam logic [TEMP_W-1:0] T_WARM_END   = 16'd150;

   // ramp divisors and the level scale
   localparam int unsigned DIV_COLD_STEEP = 92;
   localparam int unsigned DIV_COLD_GENTLE = 168;
   localparam int unsigned DIV_WARM_GENTLE = 240;
   localparam int unsigned DIV_WARM_STEEP  = 200;
   localparam int unsigned LEVEL_SCALE     = 254;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [VALUE_W-1:0] value;
   } twdc_req_type;

   typedef struct packed {
      logic [DUTY_W-1:0]  cold_duty;
      logic [DUTY_W-1:0]  warm_duty;
      logic               drive_applied;
      logic               power_now;
      logic [LEVEL_W-1:0] level_now;
      logic [TEMP_W-1:0]  temperature_now;
      logic               factory_reset_request;
   } twdc_rsp_type;

   // state after one event, carried down the pipeline
   typedef struct packed {
      logic               apply;
      logic               factory;
      logic               power;
      logic [LEVEL_W-1:0] level;
      logic [TEMP_W-1:0]  temp;
   } twdc_snap_type;

endpackage

// File: src/twdc_state.sv
module twdc_state #(
   parameter int unsigned REBOOT_LIMIT = twdc_pkg::REBOOT_LIMIT_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  twdc_pkg::twdc_req_type                 req_data,
   input  logic                                   csr_valid,
   input  logic [twdc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [twdc_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output twdc_pkg::twdc_snap_type                out_snap
);
   import twdc_pkg::*;

   logic [SPM_W-1:0]      startup_mode_ff;
   logic [TEMP_W-1:0]     startup_temp_ff;
   logic                  power_ff, power_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic [TEMP_W-1:0]     temp_ff, temp_in;
   logic [BOOT_CNT_W-1:0] boot_cnt_ff, boot_cnt_in;
   logic                  valid_ff;
   twdc_snap_type         snap_ff, snap_in;
   logic                  accept;
   logic                  apply, factory;

   assign req_ready = !valid_ff || out_ready;
   assign accept    = req_valid && req_ready;
   assign out_valid = valid_ff;
   assign out_snap  = snap_ff;

   // event decode and state update
   always_comb begin
      power_in    = power_ff;
      level_in    = level_ff;
      temp_in     = temp_ff;
      boot_cnt_in = boot_cnt_ff;
      apply       = 1'b0;
      factory     = 1'b0;
      case (req_data.mode)
         MODE_SET_POWER: begin
            power_in = (req_data.value != '0);
            apply    = 1'b1;
         end
         MODE_SET_LEVEL: begin
            if (req_data.value[LEVEL_W-1:0] == LEVEL_OFF) begin
               power_in = 1'b0;
            end else if (req_data.value[LEVEL_W-1:0] == LEVEL_ON) begin
               power_in = 1'b1;
            end else begin
               level_in = req_data.value[LEVEL_W-1:0];
            end
            apply = 1'b1;
         end
         MODE_SET_TEMP: begin
            temp_in = req_data.value;
            apply   = 1'b1;
         end
         MODE_BOOT_RESTORE: begin
            if (startup_temp_ff != KEEP_TEMPERATURE) begin
               temp_in = startup_temp_ff;
            end
            case (startup_mode_ff)
               SPM_OFF:    power_in = 1'b0;
               SPM_ON:     power_in = 1'b1;
               SPM_TOGGLE: power_in = !power_ff;
               default:    power_in = power_ff;
            endcase
            if (boot_cnt_ff != BOOT_CNT_MAX) begin
               boot_cnt_in = boot_cnt_ff + 1'b1;
            end
            if (boot_cnt_in >= BOOT_CNT_W'(REBOOT_LIMIT)) begin
               factory = 1'b1;
            end else begin
               apply = 1'b1;
            end
         end
         MODE_BOOT_CONFIRM: begin
            boot_cnt_in = '0;
         end
         default: begin
         end
      endcase
      snap_in.apply   = apply;
      snap_in.factory = factory;
      snap_in.power   = power_in;
      snap_in.level   = level_in;
      snap_in.temp    = temp_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         startup_mode_ff <= RST_STARTUP_POWER_MODE;
         startup_temp_ff <= RST_STARTUP_TEMP;
      end else if (csr_valid) begin
         if (csr_index == CSR_STARTUP_POWER_MODE) begin
            startup_mode_ff <= csr_wdata[SPM_W-1:0];
         end else if (csr_index == CSR_STARTUP_TEMPERATURE) begin
            startup_temp_ff <= csr_wdata[TEMP_W-1:0];
         end
      end
   end

   // light state, committed on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff    <= 1'b0;
         level_ff    <= RST_LEVEL;
         temp_ff     <= RST_TEMP;
         boot_cnt_ff <= '0;
      end else if (accept) begin
         power_ff    <= power_in;
         level_ff    <= level_in;
         temp_ff     <= temp_in;
         boot_cnt_ff <= boot_cnt_in;
      end
   end

   // snapshot register feeding the ramp stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         snap_ff <= snap_in;
      end
   end

`ifndef SYNTHESIS
   a_confirm_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.mode == MODE_BOOT_CONFIRM) |=> (boot_cnt_ff == '0))
      else $error("boot counter not cleared by boot confirmed");
   a_level_stored: assert property (@(posedge clock) disable iff (reset)
      (level_ff != LEVEL_OFF) && (level_ff != LEVEL_ON))
      else $error("stored level holds an on or off code");
   a_factory_only_boot: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.mode != MODE_BOOT_RESTORE) |=> !snap_ff.factory)
      else $error("factory reset raised by a non-boot event");
`endif

endmodule

// File: src/twdc_ramp.sv
module twdc_ramp #(
   parameter int unsigned DUTY_FULL_SCALE = twdc_pkg::DUTY_FULL_SCALE_DEFAULT,
   parameter int          FS_W            = $clog2(DUTY_FULL_SCALE + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  twdc_pkg::twdc_snap_type in_snap,
   output logic                    out_valid,
   input  logic                    out_ready,
   output twdc_pkg::twdc_snap_type out_snap,
   output logic [FS_W-1:0]         out_cold_base,
   output logic [FS_W-1:0]         out_warm_base
);
   import twdc_pkg::*;

   // floor(d*FS/D) as (d * FS*M) >> K, exact for d*FS below 2^(K-8)
   localparam int          RAMP_SHIFT = FS_W + 16;
   localparam int          PW         = FS_W + RAMP_SHIFT - 6;
   localparam logic [63:0] FS64       = 64'(DUTY_FULL_SCALE);
   localparam logic [63:0] ONE_K      = 64'd1 << RAMP_SHIFT;
   localparam logic [PW-1:0] RECIP_CS =
      PW'(FS64 * (ONE_K / 64'(DIV_COLD_STEEP) + 64'd1));
   localparam logic [PW-1:0] RECIP_CG =
      PW'(FS64 * (ONE_K / 64'(DIV_COLD_GENTLE) + 64'd1));
   localparam logic [PW-1:0] RECIP_WG =
      PW'(FS64 * (ONE_K / 64'(DIV_WARM_GENTLE) + 64'd1));
   localparam logic [PW-1:0] RECIP_WS =
      PW'(FS64 * (ONE_K / 64'(DIV_WARM_STEEP) + 64'd1));
   localparam logic [FS_W-1:0] FS_VAL = FS_W'(DUTY_FULL_SCALE);

   logic [TEMP_W-1:0] t;
   logic [7:0]        diff;
   logic [PW-1:0]     recip;
   logic              ramp_cold;
   logic              ramp_zero;
   logic [PW+7:0]     prod;
   logic [FS_W-1:0]   ramp;
   logic [FS_W-1:0]   cold_in, warm_in;
   logic              valid_ff;
   twdc_snap_type     snap_ff;
   logic [FS_W-1:0]   cold_ff, warm_ff;
   logic              load;

   assign in_ready      = !valid_ff || out_ready;
   assign load          = in_valid && in_ready;
   assign out_valid     = valid_ff;
   assign out_snap      = snap_ff;
   assign out_cold_base = cold_ff;
   assign out_warm_base = warm_ff;

   // segment select
   always_comb begin
      t         = in_snap.temp;
      diff      = '0;
      recip     = RECIP_CG;
      ramp_zero = 1'b0;
      ramp_cold = (t >= T_WARM_FULL);
      if (t >= T_WARM_FULL) begin
         if (t >= T_COLD_STEEP) begin
            recip = RECIP_CS;
            if (t <= T_COLD_END) begin
               diff = 8'(T_COLD_END - t);
            end else begin
               ramp_zero = 1'b1;
            end
         end else begin
            recip = RECIP_CG;
            diff  = 8'(T_COLD_BASE - t);
         end
      end else begin
         if (t >= T_WARM_STEEP) begin
            recip = RECIP_WG;
            diff  = 8'(t - T_WARM_BASE);
         end else begin
            recip = RECIP_WS;
            if (t >= T_WARM_END) begin
               diff = 8'(t - T_WARM_END);
            end else begin
               ramp_zero = 1'b1;
            end
         end
      end
   end

   // ramp value by reciprocal multiply
   assign prod = {{PW{1'b0}}, diff} * {8'b0, recip};
   assign ramp = ramp_zero ? '0 : prod[RAMP_SHIFT +: FS_W];

   always_comb begin
      if (!in_snap.apply || !in_snap.power) begin
         cold_in = '0;
         warm_in = '0;
      end else if (ramp_cold) begin
         cold_in = ramp;
         warm_in = FS_VAL;
      end else begin
         cold_in = FS_VAL;
         warm_in = ramp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         snap_ff <= in_snap;
         cold_ff <= cold_in;
         warm_ff <= warm_in;
      end
   end

endmodule

// File: src/twdc_scale.sv
module twdc_scale #(
   parameter int unsigned DUTY_FULL_SCALE = twdc_pkg::DUTY_FULL_SCALE_DEFAULT,
   parameter int          FS_W            = $clog2(DUTY_FULL_SCALE + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  twdc_pkg::twdc_snap_type in_snap,
   input  logic [FS_W-1:0]         in_cold_base,
   input  logic [FS_W-1:0]         in_warm_base,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output twdc_pkg::twdc_rsp_type  rsp_data
);
   import twdc_pkg::*;

   // floor(x/254) as (x*M) >> K, exact for x below 2^(K-8)
   localparam int XW        = FS_W + LEVEL_W;
   localparam int SCL_SHIFT = XW + 8;
   localparam int MW        = SCL_SHIFT - 7;
   localparam logic [MW-1:0] RECIP_LVL =
      MW'(((64'd1 << SCL_SHIFT) / 64'(LEVEL_SCALE)) + 64'd1);

   // level product stage
   logic          p_valid_ff;
   twdc_snap_type p_snap_ff;
   logic [XW-1:0] p_cold_ff, p_warm_ff;
   logic          p_ready;
   logic          p_load;

   // output stage
   logic            o_valid_ff;
   twdc_rsp_type    o_data_ff, o_data_in;
   logic            o_load;
   logic [XW+MW-1:0] q_cold, q_warm;

   assign in_ready = !p_valid_ff || p_ready;
   assign p_load   = in_valid && in_ready;
   assign p_ready  = !o_valid_ff || rsp_ready;
   assign o_load   = p_valid_ff && p_ready;
   assign rsp_valid = o_valid_ff;
   assign rsp_data  = o_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (in_ready) begin
         p_valid_ff <= in_valid;
      end
   end

   // both lanes times level
   always_ff @(posedge clock) begin
      if (p_load) begin
         p_snap_ff <= in_snap;
         p_cold_ff <= {{LEVEL_W{1'b0}}, in_cold_base} * {{FS_W{1'b0}}, in_snap.level};
         p_warm_ff <= {{LEVEL_W{1'b0}}, in_warm_base} * {{FS_W{1'b0}}, in_snap.level};
      end
   end

   // divide by the level scale and assemble the result
   assign q_cold = {{MW{1'b0}}, p_cold_ff} * {{XW{1'b0}}, RECIP_LVL};
   assign q_warm = {{MW{1'b0}}, p_warm_ff} * {{XW{1'b0}}, RECIP_LVL};

   always_comb begin
      o_data_in.cold_duty             = DUTY_W'(q_cold[SCL_SHIFT +: FS_W]);
      o_data_in.warm_duty             = DUTY_W'(q_warm[SCL_SHIFT +: FS_W]);
      o_data_in.drive_applied         = p_snap_ff.apply;
      o_data_in.power_now             = p_snap_ff.power;
      o_data_in.level_now             = p_snap_ff.level;
      o_data_in.temperature_now       = p_snap_ff.temp;
      o_data_in.factory_reset_request = p_snap_ff.factory;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (p_ready) begin
         o_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (o_load) begin
         o_data_ff <= o_data_in;
      end
   end

`ifndef SYNTHESIS
   a_idle_drive_zero: assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && !o_data_ff.drive_applied) |->
      (o_data_ff.cold_duty == '0 && o_data_ff.warm_duty == '0))
      else $error("duty driven on an event that applies no drive");
   a_off_drive_zero: assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && !o_data_ff.power_now) |->
      (o_data_ff.cold_duty == '0 && o_data_ff.warm_duty == '0))
      else $error("duty driven while power is off");
`endif

endmodule

// File: src/tunable_white_duty_controller.sv
// Tunable-white duty controller. Each light event (set power, set level, set
// temperature, boot restore, boot confirmed) updates the power, level,
// temperature and boot count, and returns exactly one result holding the
// cold- and warm-white duties it applied and the state after the event. Events
// are taken one per clock cycle while req_ready is high, and results come back
// in order through a state stage, a ramp stage with one reciprocal multiplier
// for the temperature division, a level product stage and an output stage that
// divides by the level scale. A stalled result waits in the output register
// while the earlier stages keep taking events until the pipe is full.
// Configuration writes are always ready and take effect on the next boot
// restore event.
module tunable_white_duty_controller #(
   parameter int unsigned DUTY_FULL_SCALE = twdc_pkg::DUTY_FULL_SCALE_DEFAULT,
   parameter int unsigned REBOOT_LIMIT    = twdc_pkg::REBOOT_LIMIT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  twdc_pkg::twdc_req_type           req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output twdc_pkg::twdc_rsp_type           rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [twdc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [twdc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import twdc_pkg::*;

   localparam int FS_W = $clog2(DUTY_FULL_SCALE + 1);

   logic            st_valid, st_ready;
   twdc_snap_type   st_snap;
   logic            rp_valid, rp_ready;
   twdc_snap_type   rp_snap;
   logic [FS_W-1:0] rp_cold, rp_warm;

   assign csr_ready = 1'b1;

   // event decode and light state
   twdc_state #(
      .REBOOT_LIMIT (REBOOT_LIMIT)
   ) u_state (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .out_valid (st_valid),
      .out_ready (st_ready),
      .out_snap  (st_snap)
   );

   // temperature ramp
   twdc_ramp #(
      .DUTY_FULL_SCALE (DUTY_FULL_SCALE),
      .FS_W            (FS_W)
   ) u_ramp (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (st_valid),
      .in_ready      (st_ready),
      .in_snap       (st_snap),
      .out_valid     (rp_valid),
      .out_ready     (rp_ready),
      .out_snap      (rp_snap),
      .out_cold_base (rp_cold),
      .out_warm_base (rp_warm)
   );

   // level scaling and result register
   twdc_scale #(
      .DUTY_FULL_SCALE (DUTY_FULL_SCALE),
      .FS_W            (FS_W)
   ) u_scale (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (rp_valid),
      .in_ready     (rp_ready),
      .in_snap      (rp_snap),
      .in_cold_base (rp_cold),
      .in_warm_base (rp_warm),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule
